// ----- src/drawdown_risk_path_evaluator_top_macros.svh -----
// ----------------------------------------------------------------------------
// Drawdown risk path evaluator assertion macros
// Short forms for the concurrent checks used in the block, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DRAWDOWN_RISK_PATH_EVALUATOR_TOP_MACROS_SVH
`define DRAWDOWN_RISK_PATH_EVALUATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/drp_pkg.sv -----
// ----------------------------------------------------------------------------
// Drawdown risk path evaluator package
// Field widths, request and register codes, payload types and the saturating
// accumulator add.
// ----------------------------------------------------------------------------
package drp_pkg;

    localparam int TABLE_ROWS_DEF  = 16;
    localparam int MAX_HORIZON_DEF = 12;

    localparam int REQ_W      = 2;
    localparam int ENTRY_W    = 4;
    localparam int HPR_W      = 32;
    localparam int PROB_W     = 32;
    localparam int PERM_W     = 48;
    localparam int ACC_W      = 48;
    localparam int LIMIT_W    = 25;
    localparam int HORIZON_W  = 4;
    localparam int RADIX_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;

    localparam int DIV_BITS   = 8;
    localparam int DIV_CHUNKS = PERM_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_CHUNKS);

    localparam logic [LIMIT_W-1:0] ONE_Q24 = 25'h100_0000;
    localparam logic [HPR_W-1:0]   BAL_ONE = 32'h0100_0000;

    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EVAL  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DRAWDOWN_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HORIZON_LEN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RUIN_MODE      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS       = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [ENTRY_W-1:0] entry_index;
        logic [HPR_W-1:0]   hpr_value;
        logic [PROB_W-1:0]  prob_value;
        logic [PERM_W-1:0]  perm_index;
    } drp_request_t;

    typedef struct packed {
        logic              path_failed;
        logic [PROB_W-1:0] path_prob;
        logic [ACC_W-1:0]  fail_total;
        logic [ACC_W-1:0]  prob_total;
    } drp_result_t;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [PROB_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + {{(ACC_W + 1 - PROB_W){1'b0}}, b};
        return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
    endfunction

endpackage

// ----- src/drp_stream_if.sv -----
// ----------------------------------------------------------------------------
// Drawdown risk path evaluator stream channel
// Valid and ready handshake with a typed payload.
// ----------------------------------------------------------------------------
interface drp_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/drawdown_risk_path_evaluator_top.sv -----
// ----------------------------------------------------------------------------
// Drawdown risk path evaluator
// Evaluates permutation paths of a return table for ruin or drawdown risk.
// ----------------------------------------------------------------------------
// The request channel carries loads of table rows, path evaluations and clears
// of the totals. A load or a clear is taken while idle and gives no result.
// An evaluation splits perm_index into horizon digits of radix num_rows and
// gives one transfer on the result channel with the failure flag, the path
// probability and both running totals.
// Each path step runs the divide, read, balance multiply, probability multiply
// and probability states: a long division unit finds the digit, handling
// eight bits of the index per cycle, the table row is read, and one shared
// 32 by 32 multiplier forms the balance and then the probability product.
// After the last step the accumulate state waits for a free output register;
// the result is then shown, and the next request may be taken in that cycle.
// The request channel is ready only while no evaluation is in progress. The
// result waits in an output register, so loads and clears go on while the
// receiver stalls; a finished evaluation holds until that register is free.
// Reset clears the totals and sets the state and configuration registers; the
// datapath registers are not reset and table rows are undefined until loaded.
// ----------------------------------------------------------------------------
`include "drawdown_risk_path_evaluator_top_macros.svh"

module drawdown_risk_path_evaluator_top #(
    parameter int TABLE_ROWS  = drp_pkg::TABLE_ROWS_DEF,
    parameter int MAX_HORIZON = drp_pkg::MAX_HORIZON_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [drp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [drp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    drp_stream_if.sink                      request,
    drp_stream_if.source                    result
);
    import drp_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_ROWS);
    localparam int STEP_W = $clog2(MAX_HORIZON + 1);
    localparam int MEM_W  = HPR_W + PROB_W;
    localparam int PROD_W = 2 * HPR_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_MULB = 3'd3;
    localparam logic [2:0] ST_MULP = 3'd4;
    localparam logic [2:0] ST_PROB = 3'd5;
    localparam logic [2:0] ST_ACC  = 3'd6;

    logic [2:0]             state_reg, state_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [STEP_W-1:0]      step_cnt_reg, step_cnt_next;
    logic [STEP_W-1:0]      steps_reg, steps_next;
    logic [RADIX_W-1:0]     radix_reg, radix_next;
    logic [RADIX_W-1:0]     rem_reg, rem_next;
    logic                   failed_reg, failed_next;
    logic                   out_valid_reg, out_valid_next;
    logic [ACC_W-1:0]       fail_accum_reg, fail_accum_next;
    logic [ACC_W-1:0]       total_accum_reg, total_accum_next;
    logic [LIMIT_W-1:0]     drawdown_limit_reg;
    logic [HORIZON_W-1:0]   horizon_len_reg;
    logic                   ruin_mode_reg;
    logic [RADIX_W-1:0]     num_rows_reg;

    logic [PERM_W-1:0]      rest_reg, rest_next;
    logic [HPR_W-1:0]       balance_reg, balance_next;
    logic [PROB_W-1:0]      prob_reg, prob_next;
    logic [PROD_W-1:0]      product_reg, product_next;
    drp_result_t            result_reg, result_next;

    logic [MEM_W-1:0]       table_mem [TABLE_ROWS];
    logic [MEM_W-1:0]       rd_reg;
    logic [HPR_W-1:0]       rd_return;
    logic [PROB_W-1:0]      rd_prob;

    logic                   in_xfer;
    logic                   out_xfer;
    logic                   load_ok;
    logic [RADIX_W-1:0]     radix_eff;
    logic [STEP_W-1:0]      steps_eff;
    logic [LIMIT_W-1:0]     limit_eff;
    logic [LIMIT_W-1:0]     threshold;
    logic [RADIX_W-1:0]     div_rem;
    logic [DIV_BITS-1:0]    div_quot;
    logic [RADIX_W:0]       div_trial;
    logic [HPR_W-1:0]       mul_a;
    logic [HPR_W-1:0]       mul_b;
    logic [PROD_W-HPR_W+7:0] bal_shift;
    logic [HPR_W-1:0]       bal_sat;
    logic                   last_step;
    logic                   out_free;

    assign in_xfer   = request.valid && request.ready;
    assign out_xfer  = result.valid && result.ready;
    assign out_free  = !out_valid_reg || result.ready;
    assign load_ok   = int'(request.data.entry_index) < TABLE_ROWS;
    assign rd_return = rd_reg[MEM_W-1:PROB_W];
    assign rd_prob   = rd_reg[PROB_W-1:0];
    assign last_step = (STEP_W'(step_cnt_reg + 1'b1) == steps_reg);

    assign request.ready = (state_reg == ST_IDLE);
    assign result.valid  = out_valid_reg;
    assign result.data   = result_reg;

    always_comb
    begin
        radix_eff = num_rows_reg;
        if (num_rows_reg == '0)
        begin
            radix_eff = RADIX_W'(1);
        end
        else if (int'(num_rows_reg) > TABLE_ROWS)
        begin
            radix_eff = RADIX_W'(TABLE_ROWS);
        end

        steps_eff = STEP_W'(horizon_len_reg);
        if (horizon_len_reg == '0)
        begin
            steps_eff = STEP_W'(1);
        end
        else if (int'(horizon_len_reg) > MAX_HORIZON)
        begin
            steps_eff = STEP_W'(MAX_HORIZON);
        end

        limit_eff = (drawdown_limit_reg > ONE_Q24) ? ONE_Q24 : drawdown_limit_reg;
        threshold = ONE_Q24 - limit_eff;
    end

    always_comb
    begin
        div_rem  = rem_reg;
        div_quot = '0;
        div_trial = '0;
        for (int b = 0; b < DIV_BITS; b++)
        begin
            div_trial = {div_rem, rest_reg[PERM_W-1-b]};
            if (div_trial >= {1'b0, radix_reg})
            begin
                div_trial = div_trial - {1'b0, radix_reg};
                div_quot[DIV_BITS-1-b] = 1'b1;
            end
            div_rem = div_trial[RADIX_W-1:0];
        end
    end

    always_comb
    begin
        mul_a     = (state_reg == ST_MULB) ? balance_reg : prob_reg;
        mul_b     = (state_reg == ST_MULB) ? rd_return : rd_prob;
        bal_shift = product_reg[PROD_W-1:24];
        bal_sat   = (|bal_shift[PROD_W-25:HPR_W]) ? {HPR_W{1'b1}} : bal_shift[HPR_W-1:0];
    end

    always_comb
    begin
        state_next       = state_reg;
        div_cnt_next     = div_cnt_reg;
        step_cnt_next    = step_cnt_reg;
        steps_next       = steps_reg;
        radix_next       = radix_reg;
        rem_next         = rem_reg;
        failed_next      = failed_reg;
        out_valid_next   = out_valid_reg && !out_xfer;
        fail_accum_next  = fail_accum_reg;
        total_accum_next = total_accum_reg;
        rest_next        = rest_reg;
        balance_next     = balance_reg;
        prob_next        = prob_reg;
        product_next     = product_reg;
        result_next      = result_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (request.data.req_type == REQ_EVAL)
                    begin
                        state_next    = ST_DIV;
                        div_cnt_next  = '0;
                        step_cnt_next = '0;
                        steps_next    = steps_eff;
                        radix_next    = radix_eff;
                        rem_next      = '0;
                        failed_next   = 1'b0;
                        rest_next     = request.data.perm_index;
                        balance_next  = BAL_ONE;
                    end
                    else if (request.data.req_type == REQ_CLEAR)
                    begin
                        fail_accum_next  = '0;
                        total_accum_next = '0;
                    end
                end
            end
            ST_DIV:
            begin
                rest_next    = {rest_reg[PERM_W-DIV_BITS-1:0], div_quot};
                rem_next     = div_rem;
                div_cnt_next = DIV_CNT_W'(div_cnt_reg + 1'b1);
                if (div_cnt_reg == DIV_CNT_W'(DIV_CHUNKS - 1))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_MULB;
            end
            ST_MULB:
            begin
                product_next = mul_a * mul_b;
                state_next   = ST_MULP;
            end
            ST_MULP:
            begin
                product_next = mul_a * mul_b;
                balance_next = bal_sat;
                if (bal_sat <= HPR_W'(threshold))
                begin
                    failed_next = 1'b1;
                end
                if (!ruin_mode_reg && (bal_sat > BAL_ONE))
                begin
                    balance_next = BAL_ONE;
                end
                state_next = ST_PROB;
            end
            ST_PROB:
            begin
                prob_next = (step_cnt_reg == '0) ? rd_prob : product_reg[PROD_W-1:HPR_W];
                if (last_step)
                begin
                    state_next = ST_ACC;
                end
                else
                begin
                    step_cnt_next = STEP_W'(step_cnt_reg + 1'b1);
                    div_cnt_next  = '0;
                    rem_next      = '0;
                    state_next    = ST_DIV;
                end
            end
            ST_ACC:
            begin
                if (out_free)
                begin
                    if (failed_reg)
                    begin
                        fail_accum_next = sat_add(fail_accum_reg, prob_reg);
                    end
                    total_accum_next        = sat_add(total_accum_reg, prob_reg);
                    result_next.path_failed = failed_reg;
                    result_next.path_prob   = prob_reg;
                    result_next.fail_total  = failed_reg ?
                                              sat_add(fail_accum_reg, prob_reg) :
                                              fail_accum_reg;
                    result_next.prob_total  = sat_add(total_accum_reg, prob_reg);
                    out_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            div_cnt_reg        <= '0;
            step_cnt_reg       <= '0;
            steps_reg          <= STEP_W'(1);
            radix_reg          <= RADIX_W'(1);
            rem_reg            <= '0;
            failed_reg         <= 1'b0;
            out_valid_reg      <= 1'b0;
            fail_accum_reg     <= '0;
            total_accum_reg    <= '0;
            drawdown_limit_reg <= '0;
            horizon_len_reg    <= HORIZON_W'(1);
            ruin_mode_reg      <= 1'b1;
            num_rows_reg       <= RADIX_W'(1);
        end
        else
        begin
            state_reg       <= state_next;
            div_cnt_reg     <= div_cnt_next;
            step_cnt_reg    <= step_cnt_next;
            steps_reg       <= steps_next;
            radix_reg       <= radix_next;
            rem_reg         <= rem_next;
            failed_reg      <= failed_next;
            out_valid_reg   <= out_valid_next;
            fail_accum_reg  <= fail_accum_next;
            total_accum_reg <= total_accum_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DRAWDOWN_LIMIT: drawdown_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                    CFG_HORIZON_LEN:    horizon_len_reg    <= cfg_wdata[HORIZON_W-1:0];
                    CFG_RUIN_MODE:      ruin_mode_reg      <= cfg_wdata[0];
                    CFG_NUM_ROWS:       num_rows_reg       <= cfg_wdata[RADIX_W-1:0];
                    default:            num_rows_reg       <= num_rows_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rest_reg    <= rest_next;
        balance_reg <= balance_next;
        prob_reg    <= prob_next;
        product_reg <= product_next;
        result_reg  <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && (request.data.req_type == REQ_LOAD) && load_ok)
        begin
            table_mem[ADDR_W'(request.data.entry_index)] <=
                {request.data.hpr_value, request.data.prob_value};
        end
        rd_reg <= table_mem[ADDR_W'(rem_reg)];
    end

    `DRP_ASSERT_SAME(a_fail_le_total, 1'b1, fail_accum_reg <= total_accum_reg, "fail total above total")
    `DRP_ASSERT_SAME(a_step_in_range, state_reg != ST_IDLE, step_cnt_reg < steps_reg, "step count past horizon")
    `DRP_ASSERT_SAME(a_digit_in_range, state_reg == ST_READ, rem_reg < radix_reg, "digit not below radix")
    `DRP_ASSERT_SAME(a_result_from_acc, $rose(out_valid_reg), $past(state_reg) == ST_ACC, "result not from accumulate")
    `DRP_ASSERT_NEXT(a_acc_to_idle, (state_reg == ST_ACC) && out_free, state_reg == ST_IDLE && out_valid_reg, "accumulate did not complete")

endmodule

// ----- test/drp_path_checker.sv -----
// ----------------------------------------------------------------------------
// Drawdown risk path evaluator checker
// Watches the configuration port and both channels, predicts every path result
// from its own copy of the tables, registers and totals, and compares each
// result transfer field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module drp_path_checker
    import drp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  req_valid,
    input  logic                  req_ready,
    input  drp_request_t          req_data,
    input  logic                  res_valid,
    input  logic                  res_ready,
    input  drp_result_t           res_data,
    output int                    mismatches,
    output int                    paths_awaited
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    logic [HPR_W-1:0]     return_rows [TABLE_ROWS_DEF];
    logic [PROB_W-1:0]    prob_rows   [TABLE_ROWS_DEF];
    logic [ACC_W-1:0]     fail_sum;
    logic [ACC_W-1:0]     total_sum;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [HORIZON_W-1:0] horizon_reg;
    logic                 ruin_reg;
    logic [RADIX_W-1:0]   rows_reg;
    drp_result_t          expected_paths [$];
    int                   errs;

    function automatic logic [ACC_W-1:0] capped_sum(input logic [ACC_W-1:0] sum,
                                                    input logic [PROB_W-1:0] p);
        logic [63:0] wide;
        wide = 64'(sum) + 64'(p);
        return (wide > 64'(ACC_MAX)) ? ACC_MAX : wide[ACC_W-1:0];
    endfunction

    function automatic drp_result_t evaluate_path(input logic [PERM_W-1:0] perm);
        drp_result_t        r;
        logic [PERM_W-1:0]  rest;
        logic [RADIX_W-1:0] radix;
        int                 steps;
        logic [LIMIT_W-1:0] lim;
        logic [31:0]        threshold;
        logic [31:0]        balance;
        logic [31:0]        prob;
        logic [63:0]        prod;
        logic [3:0]         digit;
        logic               failed;
        radix = (rows_reg == 0) ? RADIX_W'(1) :
                (rows_reg > TABLE_ROWS_DEF) ? RADIX_W'(TABLE_ROWS_DEF) : rows_reg;
        steps = (horizon_reg == 0) ? 1 :
                (horizon_reg > MAX_HORIZON_DEF) ? MAX_HORIZON_DEF : int'(horizon_reg);
        lim = (limit_reg > ONE_Q24) ? ONE_Q24 : limit_reg;
        threshold = 32'(ONE_Q24) - 32'(lim);
        balance = BAL_ONE;
        prob = '0;
        failed = 1'b0;
        rest = perm;
        for (int j = 0; j < steps; j++) begin
            digit = 4'(rest % radix);
            rest = rest / radix;
            prod = (64'(balance) * 64'(return_rows[digit])) >> 24;
            balance = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
            if (balance <= threshold) failed = 1'b1;
            if (!ruin_reg && balance > BAL_ONE) balance = BAL_ONE;
            prod = 64'(prob) * 64'(prob_rows[digit]);
            prob = (j == 0) ? prob_rows[digit] : prod[63:32];
        end
        if (failed) fail_sum = capped_sum(fail_sum, prob);
        total_sum = capped_sum(total_sum, prob);
        r.path_failed = failed;
        r.path_prob = prob;
        r.fail_total = fail_sum;
        r.prob_total = total_sum;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            errs++;
            if (errs <= 10)
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        drp_result_t want;
        if (!rst_n) begin
            foreach (return_rows[i]) begin
                return_rows[i] = '0;
                prob_rows[i] = '0;
            end
            fail_sum = '0;
            total_sum = '0;
            limit_reg = '0;
            horizon_reg = HORIZON_W'(1);
            ruin_reg = 1'b1;
            rows_reg = RADIX_W'(1);
            expected_paths.delete();
            errs = 0;
            mismatches <= 0;
            paths_awaited <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_DRAWDOWN_LIMIT: limit_reg = cfg_wdata[LIMIT_W-1:0];
                    CFG_HORIZON_LEN:    horizon_reg = cfg_wdata[HORIZON_W-1:0];
                    CFG_RUIN_MODE:      ruin_reg = cfg_wdata[0];
                    CFG_NUM_ROWS:       rows_reg = cfg_wdata[RADIX_W-1:0];
                    default: ;
                endcase
            end
            if (res_valid && res_ready) begin
                if (expected_paths.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("%0t: result transfer with no path pending", $realtime);
                end
                else begin
                    want = expected_paths.pop_front();
                    check_field("path_failed", 64'(want.path_failed), 64'(res_data.path_failed));
                    check_field("path_prob", 64'(want.path_prob), 64'(res_data.path_prob));
                    check_field("fail_total", 64'(want.fail_total), 64'(res_data.fail_total));
                    check_field("prob_total", 64'(want.prob_total), 64'(res_data.prob_total));
                end
            end
            if (req_valid && req_ready) begin
                case (req_data.req_type)
                    REQ_LOAD: begin
                        if (req_data.entry_index < TABLE_ROWS_DEF) begin
                            return_rows[req_data.entry_index] = req_data.hpr_value;
                            prob_rows[req_data.entry_index] = req_data.prob_value;
                        end
                    end
                    REQ_CLEAR: begin
                        fail_sum = '0;
                        total_sum = '0;
                    end
                    REQ_EVAL: expected_paths.push_back(evaluate_path(req_data.perm_index));
                    default: ;
                endcase
            end
            mismatches <= errs;
            paths_awaited <= expected_paths.size();
        end
    end

endmodule

// ----- test/tb_drawdown_risk_path_evaluator_top.sv -----
// ----------------------------------------------------------------------------
// Drawdown risk path evaluator testbench
// Loads return rows, evaluates paths under a series of register settings and
// clears the totals, first with directed corner cases and then with random
// requests, while both channels idle in random bursts. The checker predicts
// and compares every result; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_drawdown_risk_path_evaluator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import drp_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 45;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  calm;
    int                    mismatches;
    int                    paths_awaited;
    int                    quiet_cycles;

    drp_stream_if #(.data_t(drp_request_t)) request_ch ();
    drp_stream_if #(.data_t(drp_result_t))  result_ch ();

    drawdown_risk_path_evaluator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .request   (request_ch),
        .result    (result_ch)
    );

    drp_path_checker path_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .req_valid     (request_ch.valid),
        .req_ready     (request_ch.ready),
        .req_data      (request_ch.data),
        .res_valid     (result_ch.valid),
        .res_ready     (result_ch.ready),
        .res_data      (result_ch.data),
        .mismatches    (mismatches),
        .paths_awaited (paths_awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic drp_request_t noise_request(input logic [REQ_W-1:0] kind);
        drp_request_t r;
        r.req_type = kind;
        r.entry_index = ENTRY_W'($urandom);
        r.hpr_value = $urandom;
        r.prob_value = $urandom;
        r.perm_index = {16'($urandom), 32'($urandom)};
        return r;
    endfunction

    function automatic logic [HPR_W-1:0] draw_return();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) return $urandom_range(32'h00E0_0000, 32'h0120_0000);
        if (pick < 8) return $urandom;
        if (pick < 9) return $urandom_range(0, 32'h0100_0000);
        return ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
    endfunction

    function automatic logic [PROB_W-1:0] draw_prob();
        if ($urandom_range(0, 9) < 7) return $urandom_range(32'hC000_0000, 32'hFFFF_FFFF);
        return $urandom;
    endfunction

    task automatic send_request(input drp_request_t req);
        if (!calm && $urandom_range(0, 3) == 0) begin
            request_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        request_ch.valid <= 1'b1;
        request_ch.data <= req;
        do @(posedge clk); while (!request_ch.ready);
    endtask

    task automatic load_row(input logic [ENTRY_W-1:0] row, input logic [HPR_W-1:0] hpr,
                            input logic [PROB_W-1:0] prob);
        drp_request_t req;
        req = noise_request(REQ_LOAD);
        req.entry_index = row;
        req.hpr_value = hpr;
        req.prob_value = prob;
        send_request(req);
    endtask

    task automatic eval_path(input logic [PERM_W-1:0] perm);
        drp_request_t req;
        req = noise_request(REQ_EVAL);
        req.perm_index = perm;
        send_request(req);
    endtask

    task automatic drain();
        request_ch.valid <= 1'b0;
        do @(posedge clk); while (paths_awaited != 0);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_config(input logic [LIMIT_W-1:0] limit,
                                input logic [HORIZON_W-1:0] horizon,
                                input logic ruin, input logic [RADIX_W-1:0] rows);
        cfg_we <= 1'b1;
        cfg_index <= CFG_DRAWDOWN_LIMIT;
        cfg_wdata <= CFG_DATA_W'(limit);
        @(posedge clk);
        cfg_index <= CFG_HORIZON_LEN;
        cfg_wdata <= CFG_DATA_W'(horizon);
        @(posedge clk);
        cfg_index <= CFG_RUIN_MODE;
        cfg_wdata <= CFG_DATA_W'(ruin);
        @(posedge clk);
        cfg_index <= CFG_NUM_ROWS;
        cfg_wdata <= CFG_DATA_W'(rows);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_left > 0) stall_left--;
            else if (!calm && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 6);
            result_ch.ready <= (stall_left == 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (request_ch.valid && request_ch.ready) ||
            (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        drp_request_t       req;
        int                 counted;
        int                 pick;
        logic [LIMIT_W-1:0] limit;
        rst_n = 1'b0;
        calm = 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        request_ch.valid <= 1'b0;
        request_ch.data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_row(0, BAL_ONE, 32'hFFFF_FFFF);
        eval_path('0);
        eval_path('1);
        send_request(noise_request(REQ_UNUSED));
        send_request(noise_request(REQ_CLEAR));
        eval_path('0);
        drain();

        write_config({LIMIT_W{1'b1}}, '0, 1'b0, '0);
        eval_path({16'($urandom), 32'($urandom)});
        drain();

        write_config(ONE_Q24 >> 1, {HORIZON_W{1'b1}}, 1'b1, {RADIX_W{1'b1}});
        for (int row = 1; row < TABLE_ROWS_DEF; row++) begin
            if (row == 1) load_row(ENTRY_W'(row), '0, '0);
            else if (row == 2) load_row(ENTRY_W'(row), 32'h0080_0000, 32'h8000_0000);
            else if (row == 3) load_row(ENTRY_W'(row), 32'h0140_0000, draw_prob());
            else if (row == TABLE_ROWS_DEF - 1) load_row(ENTRY_W'(row), '1, '1);
            else load_row(ENTRY_W'(row), draw_return(), draw_prob());
        end
        eval_path('1);
        eval_path(48'h1);
        eval_path(48'h32);
        drain();

        write_config(ONE_Q24 >> 2, HORIZON_W'(MAX_HORIZON_DEF), 1'b0, RADIX_W'(TABLE_ROWS_DEF));
        eval_path(48'h23);
        eval_path('1);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            pick = $urandom_range(0, 3);
            if (pick == 0) limit = $urandom_range(0, 32'h0020_0000);
            else if (pick == 1) limit = $urandom_range(0, 32'h0100_0000);
            else if (pick == 2) limit = $urandom_range(32'h0100_0000, 32'h01FF_FFFF);
            else limit = '0;
            write_config(limit, HORIZON_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                         RADIX_W'($urandom_range(0, 31)));
            if (phase == PHASES - 1) calm <= 1'b1;
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 20) begin
                    req = noise_request(REQ_LOAD);
                    req.hpr_value = draw_return();
                    req.prob_value = draw_prob();
                    counted++;
                end
                else if (pick < 25) begin
                    req = noise_request(REQ_CLEAR);
                    counted++;
                end
                else if (pick < 30)
                    req = noise_request(REQ_UNUSED);
                else begin
                    req = noise_request(REQ_EVAL);
                    counted++;
                end
                send_request(req);
            end
            drain();
        end

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- drawdown_risk_path_evaluator_top.f -----
+incdir+src
src/drp_pkg.sv
src/drp_stream_if.sv
src/drawdown_risk_path_evaluator_top.sv
test/drp_path_checker.sv
test/tb_drawdown_risk_path_evaluator_top.sv
